// File: rtl/prefix_code_to_utf8_decoder_core_assert.svh
// Assertion macros used by the decoder checker file.
`ifndef PREFIX_CODE_TO_UTF8_DECODER_CORE_ASSERT_SVH
`define PREFIX_CODE_TO_UTF8_DECODER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed");

// next-cycle implication
`define PCU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

// File: rtl/pcu_pkg.sv
// Shared types, constants and UTF-8 helpers for the prefix code decoder.
package pcu_pkg;

    localparam int TABLE_DEPTH_DEF     = 256;
    localparam int MAX_CODE_LENGTH_DEF = 32;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_W       = 12;
    localparam int CP_W        = 21;

    localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;
    localparam logic [7:0]      NEWLINE  = 8'h0A;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_PAYLOAD = 2'd2
    } mode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_BAD_ENTRY = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       err_set;
        logic [1:0] err_val;
        logic       shift_bit;
        logic       scan_init;
        logic       scan;
        logic       tbl_write;
        logic       hit_take;
        logic       emit_text;
        logic       cell_step;
        logic       emit_nl;
        logic       flush;
        logic       next_bit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       err_any;
        logic       is_done;
        logic       tbl_empty;
        logic       tbl_full;
        logic       bad_entry;
        logic       hit;
        logic       scan_done;
        logic       prefix;
        logic       emit_ok;
        logic       out_free;
        logic       text_last;
        logic       nl_needed;
        logic       bit_last;
    } sts_t;

    // number of UTF-8 bytes minus one
    function automatic logic [1:0] utf8_nm1(input logic [CP_W-1:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7F)
            n = 2'd0;
        else if (cp <= 21'h7FF)
            n = 2'd1;
        else if (cp <= 21'hFFFF)
            n = 2'd2;
        else
            n = 2'd3;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] nm1,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = '0;
        case (nm1)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2:
            begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: rtl/pcu_ctrl.sv
// Control state machine of the prefix code decoder.
module pcu_ctrl
    import pcu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_BIT, S_SCAN, S_LWRITE, S_EMIT, S_CELL, S_NL, S_NEXT, S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FLUSH;
                    end
                    MODE_LOAD:
                    begin
                        if (sts.err_any)
                            state_next = S_FLUSH;
                        else if (sts.bad_entry)
                        begin
                            cmd.err_set = 1'b1;
                            cmd.err_val = ST_BAD_ENTRY;
                            state_next  = S_FLUSH;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    MODE_PAYLOAD: state_next = S_BIT;
                    default:      state_next = S_FLUSH;
                endcase
            end
            S_BIT:
            begin
                if (sts.err_any || sts.is_done)
                    state_next = S_FLUSH;
                else if (sts.tbl_empty)
                begin
                    cmd.err_set = 1'b1;
                    cmd.err_val = ST_EMPTY;
                    state_next  = S_FLUSH;
                end
                else
                begin
                    cmd.shift_bit = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.mode == MODE_LOAD)
                        state_next = S_LWRITE;
                    else
                    begin
                        cmd.hit_take = 1'b1;
                        state_next   = S_EMIT;
                    end
                end
                else if (sts.scan_done)
                begin
                    if (sts.mode == MODE_LOAD)
                        state_next = S_LWRITE;
                    else if (sts.prefix)
                        state_next = S_NEXT;
                    else
                    begin
                        cmd.err_set = 1'b1;
                        cmd.err_val = ST_INVALID;
                        state_next  = S_FLUSH;
                    end
                end
                else
                    cmd.scan = 1'b1;
            end
            S_LWRITE:
            begin
                if (!sts.hit && sts.tbl_full)
                begin
                    cmd.err_set = 1'b1;
                    cmd.err_val = ST_BAD_ENTRY;
                end
                else
                    cmd.tbl_write = 1'b1;
                state_next = S_FLUSH;
            end
            S_EMIT:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit_text = 1'b1;
                    if (sts.text_last)
                        state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                cmd.cell_step = 1'b1;
                state_next    = sts.nl_needed ? S_NL : S_NEXT;
            end
            S_NL:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit_nl = 1'b1;
                    state_next  = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (sts.bit_last)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.next_bit = 1'b1;
                    state_next   = S_BIT;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/pcu_datapath.sv
// Datapath of the prefix code decoder: code table, scan, positions, output staging.
module pcu_datapath
    import pcu_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   m_axis_tready,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int CW = MAX_CODE_LENGTH;
    localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TW = $clog2(TABLE_DEPTH + 1);

    // table
    logic [CW-1:0]   mem_code [TABLE_DEPTH];
    logic [LW-1:0]   mem_len  [TABLE_DEPTH];
    logic [CP_W-1:0] mem_cp   [TABLE_DEPTH];
    logic [CW-1:0]   rd_code_reg;
    logic [LW-1:0]   rd_len_reg;
    logic [CP_W-1:0] rd_cp_reg;

    // configuration
    logic [CFG_W-1:0] row_count_reg, column_count_reg;

    // item
    logic [1:0]      mode_reg;
    logic [31:0]     icode_reg;
    logic [5:0]      ilen_reg;
    logic [CP_W-1:0] icp_reg;
    logic [7:0]      ibyte_reg;
    logic [2:0]      bit_idx_reg;

    // decode state
    logic [TW-1:0]    total_reg;
    logic [CW-1:0]    pcode_reg;
    logic [LW-1:0]    plen_reg;
    logic [CFG_W-1:0] row_reg, col_reg;
    logic [1:0]       err_reg;

    // scan
    logic [TW-1:0]   addr_reg;
    logic            eval_valid_reg;
    logic [AW-1:0]   eval_idx_reg;
    logic            hit_reg, pref_reg;
    logic [AW-1:0]   hit_idx_reg;
    logic [CP_W-1:0] hit_cp_reg;

    // emission
    logic [CP_W-1:0] cp_reg;
    logic [1:0]      k_reg;

    // pending and output results
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic [1:0] pend_status_reg;
    logic       pend_done_reg;
    logic       out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic       out_user_reg, out_last_reg;

    logic [CW-1:0]   imask, key_code;
    logic [LW-1:0]   key_len, len_diff;
    logic            is_load, exact, pre_match, done_now, out_free, issue;
    logic [1:0]      nm1;
    logic [7:0]      new_byte;
    logic [CFG_W:0]  col_inc, row_inc;

    assign is_load  = (mode_reg == MODE_LOAD);
    assign imask    = ~({CW{1'b1}} << LW'(ilen_reg));
    assign key_code = is_load ? (CW'(icode_reg) & imask) : pcode_reg;
    assign key_len  = is_load ? LW'(ilen_reg) : plen_reg;
    assign len_diff = rd_len_reg - key_len;
    assign exact    = (rd_len_reg == key_len) && (rd_code_reg == key_code);
    assign pre_match = (rd_len_reg > key_len) && ((rd_code_reg >> len_diff) == key_code);
    assign done_now = (row_count_reg == '0) || (column_count_reg == '0)
                      || (row_reg >= row_count_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign issue    = cmd.scan && (addr_reg < total_reg);
    assign nm1      = utf8_nm1(cp_reg);
    assign new_byte = cmd.emit_nl ? NEWLINE : utf8_byte(cp_reg, nm1, k_reg);
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;

    always_comb
    begin
        sts           = '0;
        sts.mode      = mode_reg;
        sts.err_any   = (err_reg != ST_OK);
        sts.is_done   = done_now;
        sts.tbl_empty = (total_reg == '0);
        sts.tbl_full  = (total_reg == TW'(TABLE_DEPTH));
        sts.bad_entry = (ilen_reg == '0) || (32'(ilen_reg) > MAX_CODE_LENGTH)
                        || (icp_reg > CP_LIMIT);
        sts.hit       = hit_reg;
        sts.scan_done = (addr_reg == total_reg) && !eval_valid_reg;
        sts.prefix    = pref_reg;
        sts.emit_ok   = !pend_valid_reg || out_free;
        sts.out_free  = out_free;
        sts.text_last = (k_reg == nm1);
        sts.nl_needed = (col_inc >= {1'b0, column_count_reg})
                        && (row_inc < {1'b0, row_count_reg});
        sts.bit_last  = (bit_idx_reg == '0);
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            if (hit_reg)
                mem_cp[hit_idx_reg] <= icp_reg;
            else
            begin
                mem_code[total_reg[AW-1:0]] <= CW'(icode_reg) & imask;
                mem_len[total_reg[AW-1:0]]  <= LW'(ilen_reg);
                mem_cp[total_reg[AW-1:0]]   <= icp_reg;
            end
        end
        rd_code_reg <= mem_code[addr_reg[AW-1:0]];
        rd_len_reg  <= mem_len[addr_reg[AW-1:0]];
        rd_cp_reg   <= mem_cp[addr_reg[AW-1:0]];
    end

    // item and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            icode_reg <= s_axis_tdata[31:0];
            ilen_reg  <= s_axis_tdata[37:32];
            icp_reg   <= s_axis_tdata[58:38];
            ibyte_reg <= s_axis_tdata[66:59];
        end
        if (cmd.hit_take)
            cp_reg <= hit_cp_reg;
        if (cmd.scan && eval_valid_reg && exact)
        begin
            hit_idx_reg <= eval_idx_reg;
            hit_cp_reg  <= rd_cp_reg;
        end
        if (issue)
            eval_idx_reg <= addr_reg[AW-1:0];
        if (cmd.emit_text || cmd.emit_nl)
        begin
            pend_byte_reg   <= new_byte;
            pend_status_reg <= err_reg;
            pend_done_reg   <= done_now;
        end
        if (cmd.flush)
        begin
            if (pend_valid_reg)
                out_data_reg <= {5'd0, pend_done_reg, pend_status_reg, pend_byte_reg};
            else
                out_data_reg <= {5'd0, done_now, err_reg, 8'd0};
            out_user_reg <= pend_valid_reg;
            out_last_reg <= 1'b1;
        end
        else if ((cmd.emit_text || cmd.emit_nl) && pend_valid_reg)
        begin
            out_data_reg <= {5'd0, pend_done_reg, pend_status_reg, pend_byte_reg};
            out_user_reg <= 1'b1;
            out_last_reg <= 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
            mode_reg         <= '0;
            bit_idx_reg      <= '0;
            total_reg        <= '0;
            pcode_reg        <= '0;
            plen_reg         <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            err_reg          <= ST_OK;
            addr_reg         <= '0;
            eval_valid_reg   <= 1'b0;
            hit_reg          <= 1'b0;
            pref_reg         <= 1'b0;
            k_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_count_reg <= cfg_data;
                else
                    column_count_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                mode_reg    <= s_axis_tuser;
                bit_idx_reg <= 3'd7;
            end
            if (cmd.next_bit)
                bit_idx_reg <= bit_idx_reg - 1'b1;
            if (cmd.clear)
            begin
                total_reg <= '0;
                pcode_reg <= '0;
                plen_reg  <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
                err_reg   <= ST_OK;
            end
            if (cmd.err_set)
                err_reg <= cmd.err_val;
            if (cmd.tbl_write && !hit_reg)
                total_reg <= total_reg + 1'b1;
            if (cmd.shift_bit)
            begin
                pcode_reg <= {pcode_reg[CW-2:0], ibyte_reg[bit_idx_reg]};
                plen_reg  <= plen_reg + 1'b1;
            end
            if (cmd.shift_bit || cmd.scan_init)
            begin
                addr_reg       <= '0;
                eval_valid_reg <= 1'b0;
                hit_reg        <= 1'b0;
                pref_reg       <= 1'b0;
            end
            else
            begin
                eval_valid_reg <= issue;
                if (issue)
                    addr_reg <= addr_reg + 1'b1;
                if (cmd.scan && eval_valid_reg)
                begin
                    if (exact)
                        hit_reg <= 1'b1;
                    if (pre_match)
                        pref_reg <= 1'b1;
                end
            end
            if (cmd.hit_take)
            begin
                k_reg     <= '0;
                pcode_reg <= '0;
                plen_reg  <= '0;
            end
            if (cmd.emit_text)
                k_reg <= k_reg + 1'b1;
            if (cmd.cell_step)
            begin
                if (col_inc >= {1'b0, column_count_reg})
                begin
                    col_reg <= '0;
                    row_reg <= row_inc[CFG_W-1:0];
                end
                else
                    col_reg <= col_inc[CFG_W-1:0];
            end
            if (cmd.emit_text || cmd.emit_nl)
                pend_valid_reg <= 1'b1;
            if (cmd.flush)
                pend_valid_reg <= 1'b0;
            if (cmd.flush || ((cmd.emit_text || cmd.emit_nl) && pend_valid_reg))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/prefix_code_to_utf8_decoder_core.sv
// Top level of the table-driven prefix code to UTF-8 decoder.
// One transaction is taken at a time. A clear or an ignored item needs no table sweep.
// A table load sweeps the stored entries once and every payload bit sweeps them once,
// since the code table has a single read port; each emitted UTF-8 byte or newline and
// each decoded cell take their own states, and emission waits while the output is
// stalled. The table needs no clearing pass after reset.
module prefix_code_to_utf8_decoder_core
    import pcu_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_code, entry_length, entry_codepoint, payload_byte, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_byte, status, done_res, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // byte_valid
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    cmd_t cmd;
    sts_t sts;

    pcu_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    pcu_datapath #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: rtl/pcu_checker.sv
// Port-level checker for the decoder and its bind to the top level.
`include "prefix_code_to_utf8_decoder_core_assert.svh"

module pcu_checker
    import pcu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    `PCU_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PCU_ASSERT_IMP(a_status_only_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
    `PCU_ASSERT_IMP(a_status_only_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    `PCU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind prefix_code_to_utf8_decoder_core pcu_checker u_pcu_checker (.*);
